FILE: src/block_range_bitmap_top_assert.svh
// assertion macros for the block range bitmap
`ifndef BLOCK_RANGE_BITMAP_TOP_ASSERT_SVH
`define BLOCK_RANGE_BITMAP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define BRB_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("block_range_bitmap assertion failed");
// checked on every edge, reset included
`define BRB_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("block_range_bitmap assertion failed");
`else
`define BRB_ASSERT(lbl, clk_s, rstn_s, prop)
`define BRB_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

FILE: src/brb_pkg.sv
// shared types and constants of the block range bitmap
`default_nettype none
package brb_pkg;

  localparam int BLK_W     = 10;   // block index width
  localparam int CNT_W     = 11;   // set count width
  localparam int MODE_W    = 3;
  localparam int WORD_BITS = 64;
  localparam int WORD_SH   = 6;    // log2 of the word width
  localparam int BLK_SPAN  = 1024; // blocks addressable by a 10-bit index

  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OVERLAP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic start_walk;
    logic start_scan;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              bad;
    logic              walk_done;
    logic              scan_done;
  } status_t;

endpackage
`default_nettype wire

FILE: src/brb_ram.sv
// generic single write port ram with registered read
`default_nettype none
module brb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/brb_ctrl.sv
// controller state machine: handshakes and sequencing of one request
`default_nettype none
module brb_ctrl import brb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.bad && (st.mode == MODE_ADD || st.mode == MODE_REMOVE ||
                       st.mode == MODE_OVERLAP)) begin
          state_nxt = ST_FINISH;
        end else begin
          unique case (st.mode)
            MODE_ADD, MODE_REMOVE, MODE_OVERLAP: begin
              cmd.start_walk = 1'b1;
              state_nxt      = ST_WALK;
            end
            MODE_FIRST: begin
              cmd.start_scan = 1'b1;
              state_nxt      = ST_SCAN;
            end
            MODE_CLEAR: begin
              cmd.clear_all = 1'b1;
              state_nxt     = ST_FINISH;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (st.walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: src/brb_dpath.sv
// datapath: bitmap words, range walk, first run scan, set count, result register
`default_nettype none
module brb_dpath import brb_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output status_t                st,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [BLK_W-1:0]  in_range_start,
  input  wire logic [BLK_W-1:0]  in_range_end,
  output logic                   out_changed,
  output logic                   out_overlap,
  output logic                   out_first_valid,
  output logic [BLK_W-1:0]       out_first_start,
  output logic [BLK_W-1:0]       out_first_end,
  output logic [CNT_W-1:0]       out_set_count,
  output logic                   out_is_empty,
  output logic                   out_range_error
);

  // only the first BLK_SPAN blocks can ever be reached by a 10-bit range
  localparam int CAP        = (MAX_BLOCKS < BLK_SPAN) ? MAX_BLOCKS : BLK_SPAN;
  localparam int USED_WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(USED_WORDS - 1);
  localparam logic [BLK_W-1:0]  TOP_BLK  = BLK_W'(USED_WORDS * WORD_BITS - 1);

  function automatic logic [WORD_SH-1:0] enc64(input logic [WORD_BITS-1:0] oh);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int b = 0; b < WORD_SH; b++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> b) & 1) == 1) begin
          r[b] = r[b] | oh[i];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] lowest(input logic [WORD_BITS-1:0] x);
    return x & (~x + WORD_BITS'(1));
  endfunction

  // byte counts first, then a short sum of eight bytes
  function automatic logic [WORD_SH:0] pop64(input logic [WORD_BITS-1:0] x);
    logic [3:0]       bc;
    logic [WORD_SH:0] s;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      bc = '0;
      for (int j = 0; j < 8; j++) begin
        bc = bc + 4'(x[k*8+j]);
      end
      s = s + (WORD_SH+1)'(bc);
    end
    return s;
  endfunction

  // request registers
  logic [MODE_W-1:0]  mode_r;
  logic               bad_r;
  logic [WIDX_W-1:0]  ws_r, we_r;
  logic [WORD_SH-1:0] rs_lo_r, re_lo_r;

  // word sequencing
  logic              issuing_r;
  logic [WIDX_W-1:0] rd_idx_r, end_idx_r;
  logic              proc_vld_r;
  logic [WIDX_W-1:0] proc_idx_r;
  logic [USED_WORDS-1:0] wvld_r;
  logic              wvld_q_r;
  logic [WORD_BITS-1:0] ram_rd_data;

  // accumulators
  logic                 changed_r, overlap_r;
  logic [WORD_BITS-1:0] diff_r;
  logic                 diff_vld_r;
  logic                 diff_set_r;
  logic [CNT_W-1:0]     count_r;

  // first run scan
  logic             scan_run_r, scan_fin_r;
  logic             fvalid_r;
  logic [BLK_W-1:0] fstart_r, fend_r;

  logic                 is_modify, is_walk, is_scan;
  logic [WORD_BITS-1:0] word, mask, new_word, diff;
  logic [WORD_SH-1:0]   lo, hi;
  logic                 wr_en;
  logic [BLK_W-1:0]     blk_base;
  logic [WORD_BITS-1:0] t_find, t_run;
  logic                 scan_step;

  assign is_modify = (mode_r == MODE_ADD) || (mode_r == MODE_REMOVE);
  assign is_walk   = is_modify || (mode_r == MODE_OVERLAP);
  assign is_scan   = (mode_r == MODE_FIRST);

  // a word never written since the last clear reads as zero
  assign word = ram_rd_data & {WORD_BITS{wvld_q_r}};

  assign lo       = (proc_idx_r == ws_r) ? rs_lo_r : '0;
  assign hi       = (proc_idx_r == we_r) ? re_lo_r : '1;
  assign mask     = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
  assign new_word = (mode_r == MODE_ADD) ? (word | mask) : (word & ~mask);
  assign diff     = word ^ new_word;
  assign wr_en    = proc_vld_r && is_modify;

  assign blk_base  = BLK_W'({proc_idx_r, {WORD_SH{1'b0}}});
  assign t_find    = ~(word | (word - WORD_BITS'(1)));
  assign t_run     = ~word;
  assign scan_step = proc_vld_r && is_scan && !scan_fin_r;

  brb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (USED_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (proc_idx_r),
    .wr_data (new_word),
    .rd_en   (issuing_r),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      bad_r   <= (int'(in_range_end) >= MAX_BLOCKS) || (in_range_start > in_range_end);
      ws_r    <= WIDX_W'(in_range_start >> WORD_SH);
      we_r    <= WIDX_W'(in_range_end >> WORD_SH);
      rs_lo_r <= in_range_start[WORD_SH-1:0];
      re_lo_r <= in_range_end[WORD_SH-1:0];
    end
    proc_idx_r <= rd_idx_r;
    wvld_q_r   <= wvld_r[rd_idx_r];
    diff_r     <= diff;
    diff_set_r <= (mode_r == MODE_ADD);
  end

  // read issue: one word per cycle from the first index to the last or to scan end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r  <= 1'b0;
      proc_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      end_idx_r  <= '0;
    end else begin
      proc_vld_r <= issuing_r;
      if (cmd.start_walk) begin
        rd_idx_r  <= ws_r;
        end_idx_r <= we_r;
        issuing_r <= 1'b1;
      end else if (cmd.start_scan) begin
        rd_idx_r  <= '0;
        end_idx_r <= LAST_IDX;
        issuing_r <= 1'b1;
      end else if (issuing_r) begin
        if (rd_idx_r == end_idx_r || (is_scan && scan_fin_r)) begin
          issuing_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + WIDX_W'(1);
        end
      end
    end
  end

  // valid bits, set count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r     <= '0;
      count_r    <= '0;
      diff_vld_r <= 1'b0;
    end else begin
      diff_vld_r <= wr_en;
      if (cmd.clear_all) begin
        wvld_r  <= '0;
        count_r <= '0;
      end else begin
        if (wr_en) begin
          wvld_r[proc_idx_r] <= 1'b1;
        end
        if (diff_vld_r) begin
          if (diff_set_r) begin
            count_r <= count_r + CNT_W'(pop64(diff_r));
          end else begin
            count_r <= count_r - CNT_W'(pop64(diff_r));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
      overlap_r <= 1'b0;
    end else if (cmd.load) begin
      changed_r <= 1'b0;
      overlap_r <= 1'b0;
    end else if (proc_vld_r && is_walk) begin
      if (is_modify && (diff != '0)) begin
        changed_r <= 1'b1;
      end
      if (mode_r == MODE_OVERLAP && ((word & mask) != '0)) begin
        overlap_r <= 1'b1;
      end
    end
  end

  // first run: find the lowest set bit, then the first clear bit above it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_run_r <= 1'b0;
      scan_fin_r <= 1'b0;
      fvalid_r   <= 1'b0;
      fstart_r   <= '0;
      fend_r     <= '0;
    end else if (cmd.load) begin
      scan_run_r <= 1'b0;
      scan_fin_r <= 1'b0;
      fvalid_r   <= 1'b0;
      fstart_r   <= '0;
      fend_r     <= '0;
    end else if (scan_step) begin
      if (!scan_run_r) begin
        if (word != '0) begin
          fvalid_r <= 1'b1;
          fstart_r <= blk_base + BLK_W'(enc64(lowest(word)));
          if (t_find != '0) begin
            fend_r     <= blk_base + BLK_W'(enc64(lowest(t_find))) - BLK_W'(1);
            scan_fin_r <= 1'b1;
          end else if (proc_idx_r == LAST_IDX) begin
            fend_r     <= TOP_BLK;
            scan_fin_r <= 1'b1;
          end else begin
            scan_run_r <= 1'b1;
          end
        end else if (proc_idx_r == LAST_IDX) begin
          scan_fin_r <= 1'b1;
        end
      end else begin
        if (t_run != '0) begin
          fend_r     <= blk_base + BLK_W'(enc64(lowest(t_run))) - BLK_W'(1);
          scan_fin_r <= 1'b1;
        end else if (proc_idx_r == LAST_IDX) begin
          fend_r     <= TOP_BLK;
          scan_fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_changed     <= changed_r;
      out_overlap     <= overlap_r;
      out_first_valid <= fvalid_r;
      out_first_start <= fstart_r;
      out_first_end   <= fend_r;
      out_set_count   <= count_r;
      out_is_empty    <= (count_r == '0);
      out_range_error <= bad_r && (is_walk);
    end
  end

  assign st.mode      = mode_r;
  assign st.bad       = bad_r;
  assign st.walk_done = !issuing_r && !proc_vld_r && !diff_vld_r;
  assign st.scan_done = scan_fin_r;

endmodule
`default_nettype wire

FILE: src/block_range_bitmap_top.sv
// top level of the block range bitmap: controller, datapath and checks
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_mode, in_range_start, in_range_end
//   out      output     out_valid / out_ready  out_changed .. out_range_error
//
// one request at a time: add and remove read-modify-write one word per cycle over the
// words in range, overlap reads one word per cycle over them, and first run reads the
// store words until the run ends; clear all, unknown modes and bad ranges skip the
// walk. in_ready returns with out_valid, so the next request can be taken while the
// result waits. the bitmap is cleared at once by per-word valid bits, so no clearing
// pass follows reset. a finished request waits for out_ready.
`default_nettype none
module block_range_bitmap_top import brb_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [BLK_W-1:0]  in_range_start,
  input  wire logic [BLK_W-1:0]  in_range_end,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_changed,
  output logic                   out_overlap,
  output logic                   out_first_valid,
  output logic [BLK_W-1:0]       out_first_start,
  output logic [BLK_W-1:0]       out_first_end,
  output logic [CNT_W-1:0]       out_set_count,
  output logic                   out_is_empty,
  output logic                   out_range_error
);

`include "block_range_bitmap_top_assert.svh"

  localparam int CAP = (MAX_BLOCKS < BLK_SPAN) ? MAX_BLOCKS : BLK_SPAN;

  cmd_t    cmd;
  status_t st;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  brb_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_mode         (in_mode),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .out_changed     (out_changed),
    .out_overlap     (out_overlap),
    .out_first_valid (out_first_valid),
    .out_first_start (out_first_start),
    .out_first_end   (out_first_end),
    .out_set_count   (out_set_count),
    .out_is_empty    (out_is_empty),
    .out_range_error (out_range_error)
  );

  // one request in flight: no second transaction right after an accepted one
  `BRB_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // count never passes the reachable store size
  `BRB_ASSERT(a_count_bound, clk, rst_n, out_valid |-> (int'(out_set_count) <= CAP))
  // a bad range leaves the store untouched and reports nothing else
  `BRB_ASSERT(a_error_quiet, clk, rst_n,
    (out_valid && out_range_error) |-> (!out_changed && !out_overlap && !out_first_valid))
  // result register is empty right after reset
  `BRB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule
`default_nettype wire

FILE: sim/brb_checker.sv
// checker for the block range bitmap: predicts each request and compares every result
module brb_checker import brb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [BLK_W-1:0]  in_range_start,
  input  wire logic [BLK_W-1:0]  in_range_end,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_changed,
  input  wire logic              out_overlap,
  input  wire logic              out_first_valid,
  input  wire logic [BLK_W-1:0]  out_first_start,
  input  wire logic [BLK_W-1:0]  out_first_end,
  input  wire logic [CNT_W-1:0]  out_set_count,
  input  wire logic              out_is_empty,
  input  wire logic              out_range_error,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BLOCKS = 1024;
  localparam int STORE_WORDS  = STORE_BLOCKS / WORD_BITS;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic              changed;
    logic              overlap;
    logic              first_valid;
    logic [BLK_W-1:0]  first_start;
    logic [BLK_W-1:0]  first_end;
    logic [CNT_W-1:0]  set_count;
    logic              is_empty;
    logic              range_error;
  } bitmap_result_t;

  logic [WORD_BITS-1:0] bitmap_words [STORE_WORDS];
  int                   blocks_set;
  bitmap_result_t       expected_results [$];

  function automatic logic block_is_set(input int b);
    return bitmap_words[b / WORD_BITS][b % WORD_BITS];
  endfunction

  // applies one request to the bitmap copy and returns the result it should give
  task automatic predict_request(input logic [MODE_W-1:0] mode, input int rs, input int re,
                                 output bitmap_result_t r);
    int   b;
    int   e;
    logic fill;
    r = '{default: '0};
    r.mode = mode;
    if (mode <= MODE_OVERLAP && (re >= STORE_BLOCKS || rs > re)) begin
      r.range_error = 1'b1;
    end else begin
      case (mode)
        MODE_ADD, MODE_REMOVE: begin
          fill = (mode == MODE_ADD);
          for (b = rs; b <= re; b++) begin
            if (block_is_set(b) != fill) begin
              bitmap_words[b / WORD_BITS][b % WORD_BITS] = fill;
              r.changed = 1'b1;
              if (fill) blocks_set++;
              else if (blocks_set > 0) blocks_set--;
            end
          end
        end
        MODE_OVERLAP: begin
          for (b = rs; b <= re; b++) r.overlap |= block_is_set(b);
        end
        MODE_FIRST: begin
          b = 0;
          while (b < STORE_BLOCKS && !block_is_set(b)) b++;
          if (b < STORE_BLOCKS) begin
            e = b;
            // a run still set at the last block stops there
            while (e + 1 < STORE_BLOCKS && block_is_set(e + 1)) e++;
            r.first_valid = 1'b1;
            r.first_start = b[BLK_W-1:0];
            r.first_end   = e[BLK_W-1:0];
          end
        end
        MODE_CLEAR: begin
          foreach (bitmap_words[w]) bitmap_words[w] = '0;
          blocks_set = 0;
        end
        default: ;  // unknown modes leave the store alone
      endcase
    end
    r.set_count = blocks_set[CNT_W-1:0];
    r.is_empty  = (blocks_set == 0);
  endtask

  task automatic check_field(input string name, input logic [MODE_W-1:0] mode,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: mode %0d %s expected %0d actual %0d", $time, mode, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bitmap_result_t want;
    if (!rst_n) begin
      foreach (bitmap_words[w]) bitmap_words[w] = '0;
      blocks_set = 0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unrequested transaction, expected none actual set_count %0d",
                   $time, out_set_count);
        end else begin
          want = expected_results.pop_front();
          check_field("changed", want.mode, want.changed, out_changed);
          check_field("overlap", want.mode, want.overlap, out_overlap);
          check_field("first_valid", want.mode, want.first_valid, out_first_valid);
          check_field("first_start", want.mode, want.first_start, out_first_start);
          check_field("first_end", want.mode, want.first_end, out_first_end);
          check_field("set_count", want.mode, want.set_count, out_set_count);
          check_field("is_empty", want.mode, want.is_empty, out_is_empty);
          check_field("range_error", want.mode, want.range_error, out_range_error);
        end
      end
      if (in_valid && in_ready) begin
        predict_request(in_mode, in_range_start, in_range_end, want);
        expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: sim/tb.sv
// testbench top: drives range requests into the block range bitmap and gives the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
  localparam int LAST_BLOCK      = BLK_SPAN - 1;
  localparam int ITEMS_PER_PHASE = 470;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [BLK_W-1:0]  in_range_start = '0;
  logic [BLK_W-1:0]  in_range_end = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_changed;
  logic              out_overlap;
  logic              out_first_valid;
  logic [BLK_W-1:0]  out_first_start;
  logic [BLK_W-1:0]  out_first_end;
  logic [CNT_W-1:0]  out_set_count;
  logic              out_is_empty;
  logic              out_range_error;
  int                mismatches;
  int                outstanding;

  int   sender_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  always #6 clk = ~clk;

  block_range_bitmap_top dut (.*);
  brb_checker checker_i (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_request(input logic [MODE_W-1:0] mode, input int rs, input int re);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_range_start <= rs[BLK_W-1:0];
    in_range_end   <= re[BLK_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    int                pick;
    int                len;
    int                rs;
    int                re;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(99);
    rs = $urandom_range(LAST_BLOCK);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: len = $urandom_range(15);
      7, 8:                len = $urandom_range(100);
      default:             len = $urandom_range(LAST_BLOCK);
    endcase
    re = (rs + len > LAST_BLOCK) ? LAST_BLOCK : rs + len;
    if (pick < 30) mode = MODE_ADD;
    else if (pick < 50) mode = MODE_REMOVE;
    else if (pick < 68) mode = MODE_OVERLAP;
    else if (pick < 80) mode = MODE_FIRST;
    else if (pick < 82) mode = MODE_CLEAR;
    else if (pick < 92) begin
      // start past end
      mode = (pick < 85) ? MODE_ADD : (pick < 88) ? MODE_REMOVE : MODE_OVERLAP;
      rs = $urandom_range(1, LAST_BLOCK);
      re = $urandom_range(0, rs - 1);
    end else if (pick < 96) begin
      case ($urandom_range(2))
        0:       mode = MODE_RSVD5;
        1:       mode = MODE_RSVD6;
        default: mode = MODE_RSVD7;
      endcase
      rs = $urandom_range(LAST_BLOCK);
      re = $urandom_range(LAST_BLOCK);
    end else begin
      // ranges pinned to either end of the store
      mode = (pick < 98) ? MODE_ADD : (pick < 99) ? MODE_REMOVE : MODE_OVERLAP;
      if ($urandom_range(1)) rs = 0;
      else re = LAST_BLOCK;
    end
    // range fields are don't-care for first run and clear, so scramble them
    if ((mode == MODE_FIRST || mode == MODE_CLEAR) && $urandom_range(1)) begin
      rs = $urandom_range(LAST_BLOCK);
      re = $urandom_range(LAST_BLOCK);
    end
    send_request(mode, rs, re);
  endtask

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(MODE_ADD, 0, LAST_BLOCK);       // full store, count reaches 1024
    send_request(MODE_FIRST, 0, 0);
    send_request(MODE_ADD, 0, LAST_BLOCK);       // nothing changes
    send_request(MODE_REMOVE, 0, 0);
    send_request(MODE_FIRST, LAST_BLOCK, 0);     // run reaches the last block
    send_request(MODE_OVERLAP, 0, 0);
    send_request(MODE_OVERLAP, LAST_BLOCK, LAST_BLOCK);
    send_request(MODE_ADD, LAST_BLOCK, 0);       // bad ranges
    send_request(MODE_REMOVE, 1, 0);
    send_request(MODE_OVERLAP, 700, 699);
    send_request(MODE_REMOVE, 1, LAST_BLOCK - 1);
    send_request(MODE_FIRST, 5, 9);
    send_request(MODE_REMOVE, 0, LAST_BLOCK);
    send_request(MODE_REMOVE, 0, LAST_BLOCK);
    send_request(MODE_FIRST, 0, LAST_BLOCK);     // empty store
    send_request(MODE_ADD, 63, 64);              // run across a word boundary
    send_request(MODE_ADD, 66, 70);
    send_request(MODE_FIRST, 0, 0);
    send_request(MODE_OVERLAP, 65, 65);
    send_request(MODE_RSVD5, 1, 2);
    send_request(MODE_RSVD6, LAST_BLOCK, 0);
    send_request(MODE_RSVD7, 0, LAST_BLOCK);
    send_request(MODE_CLEAR, 512, 3);
    send_request(MODE_OVERLAP, 0, LAST_BLOCK);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 50; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 50; end
        default: begin sender_idle_pct = 9;  stall_pct = 9;  end
      endcase
      if (phase == 3) begin
        // back-pressure: hold the output while requests keep coming
        in_valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      repeat (ITEMS_PER_PHASE) send_random_request();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: block_range_bitmap_top.f
+incdir+src
src/brb_pkg.sv
src/brb_ram.sv
src/brb_ctrl.sv
src/brb_dpath.sv
src/block_range_bitmap_top.sv
sim/brb_checker.sv
sim/tb.sv
